>>> sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// shared types, constants and the crc-8 byte step of the sensor frame converter
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_CRC_MISMATCH = 2'd1,
		ST_BUS_ERROR    = 2'd2
	} status_t;

	typedef enum logic {
		KIND_TEMP  = 1'b0,
		KIND_HUMID = 1'b1
	} kind_t;

	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [7:0]  CRC_POLY   = 8'h31;

	localparam logic [14:0] CEL_SCALE  = 15'd17500;
	localparam logic [14:0] HUM_SCALE  = 15'd10000;
	localparam logic [14:0] FAH_SCALE  = 15'd31500;

	localparam logic signed [15:0] CEL_OFFSET = -16'sd4500;
	localparam logic signed [16:0] FAH_OFFSET = -17'sd4900;

	// msb-first crc-8 over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] dat);
		logic [7:0] c;
		c = acc ^ dat;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/scc_if.sv
// ----------------------------------------------------------------------------
// scc_if
// valid/ready channels for received frames and converted results
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_frame_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_high;
	logic [7:0] data_low;
	logic [7:0] check_byte;
	logic       bus_error;

	modport source (output valid, kind, data_high, data_low, check_byte, bus_error,
		input ready);
	modport sink (input valid, kind, data_high, data_low, check_byte, bus_error,
		output ready);
endinterface

interface scc_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [14:0] reading_centi;
	logic signed [15:0] fahrenheit_centi;
	logic [7:0]         computed_crc;

	modport source (output valid, status, reading_centi, fahrenheit_centi, computed_crc,
		input ready);
	modport sink (input valid, status, reading_centi, fahrenheit_centi, computed_crc,
		output ready);
endinterface

`default_nettype wire

>>> sv/sensor_frame_crc_convert_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_core
// crc-8 check of a two-byte sensor frame and conversion to hundredths of
// degC / degF or percent humidity
// ----------------------------------------------------------------------------
// channel     dir  transaction
// in_frame    in   kind, data_high, data_low, check_byte, bus_error
// out_result  out  status, reading_centi, fahrenheit_centi, computed_crc
//
// three register stages: crc of first byte, crc of second byte and scale
// multiply, status select and offset add into the output register
// one transaction per cycle sustained while out_result.ready is high
// each stage holds its item while the next one is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated
// arst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_convert_core
	import scc_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	scc_frame_if.sink         in_frame,
	scc_result_if.source      out_result
);

	logic        v_s1, v_s2, v_s3;
	logic        adv_s1, adv_s2, adv_s3;

	kind_t       kind_s1, kind_s2;
	logic [7:0]  lo_s1;
	logic [15:0] raw_s1;
	logic [7:0]  chk_s1, chk_s2;
	logic        berr_s1, berr_s2;
	logic [7:0]  crc_s1, crc_s2;
	logic [30:0] prod_s2, fprod_s2;

	status_t            status_s3;
	logic signed [14:0] reading_s3;
	logic signed [15:0] fahr_s3;
	logic [7:0]         crc_s3;

	logic [7:0]         crc_full;
	logic [14:0]        scale;
	status_t            status_nx;
	logic signed [15:0] cel_sum;
	logic signed [16:0] fah_sum;

	assign adv_s3 = !v_s3 || out_result.ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_frame.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_frame.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv_s1 && in_frame.valid) begin
			kind_s1 <= kind_t'(in_frame.kind);
			raw_s1  <= {in_frame.data_high, in_frame.data_low};
			lo_s1   <= in_frame.data_low;
			chk_s1  <= in_frame.check_byte;
			berr_s1 <= in_frame.bus_error;
			crc_s1  <= crc8_byte(CRC_INIT, in_frame.data_high);
		end
	end

	// stage 2
	assign crc_full = crc8_byte(crc_s1, lo_s1);
	assign scale    = (kind_s1 == KIND_TEMP) ? CEL_SCALE : HUM_SCALE;

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			kind_s2  <= kind_s1;
			chk_s2   <= chk_s1;
			berr_s2  <= berr_s1;
			crc_s2   <= crc_full;
			prod_s2  <= 31'(scale) * 31'(raw_s1);
			fprod_s2 <= 31'(FAH_SCALE) * 31'(raw_s1);
		end
	end

	// stage 3
	always_comb begin
		if (berr_s2) begin
			status_nx = ST_BUS_ERROR;
		end else if (crc_s2 != chk_s2) begin
			status_nx = ST_CRC_MISMATCH;
		end else begin
			status_nx = ST_OK;
		end
	end

	assign cel_sum = (kind_s2 == KIND_TEMP)
		? signed'({1'b0, prod_s2[30:16]}) + CEL_OFFSET
		: signed'({1'b0, prod_s2[30:16]});
	assign fah_sum = signed'({2'b00, fprod_s2[30:16]}) + FAH_OFFSET;

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			status_s3 <= status_nx;
			crc_s3    <= crc_s2;
			if (status_nx == ST_OK) begin
				reading_s3 <= cel_sum[14:0];
				fahr_s3    <= (kind_s2 == KIND_TEMP) ? fah_sum[15:0] : 16'sd0;
			end else begin
				reading_s3 <= 15'sd0;
				fahr_s3    <= 16'sd0;
			end
		end
	end

	assign out_result.valid            = v_s3;
	assign out_result.status           = status_s3;
	assign out_result.reading_centi    = reading_s3;
	assign out_result.fahrenheit_centi = fahr_s3;
	assign out_result.computed_crc     = crc_s3;

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && status_s3 != ST_OK) |-> (reading_s3 == 15'sd0 && fahr_s3 == 16'sd0))
		else $error("reading not cleared on failed frame");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_frame.valid && in_frame.ready) |=> v_s1)
		else $error("accepted frame missing from stage 1");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv_s3) |=> (v_s2 && $stable(crc_s2) && $stable(prod_s2)))
		else $error("stage 2 item lost under stall");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(raw_s1)))
		else $error("stage 1 item lost under stall");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sensor_frame_crc_convert_core: frames are sent back to back or with
// bursty valid and checked against a local crc-8 and fixed-point conversion,
// with random output stalls, a long output hold-off and a full drain pause
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		status_t            status;
		logic signed [14:0] reading_centi;
		logic signed [15:0] fahrenheit_centi;
		logic [7:0]         computed_crc;
	} conv_result_t;

	logic clk;
	logic arst_n;

	scc_frame_if  frame_bus();
	scc_result_if result_bus();

	sensor_frame_crc_convert_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_frame   (frame_bus),
		.out_result (result_bus)
	);

	conv_result_t expected_results[$];
	int  errors = 0;
	int  burst_left = 0;
	bit  tx_bursty = 1'b0;
	bit  rx_stalls = 1'b0;
	bit  hold_request = 1'b0;
	int  stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] frame_crc8(input logic [7:0] hi, input logic [7:0] lo);
		logic [15:0] bits;
		logic [7:0]  c;
		logic        fb;
		bits = {hi, lo};
		c = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			fb = c[7] ^ bits[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic conv_result_t convert_frame(input kind_t kind, input logic [7:0] hi,
		input logic [7:0] lo, input logic [7:0] chk, input logic berr);
		conv_result_t     r;
		longint unsigned  raw;
		longint           reading;
		longint           fahr;
		raw = 64'({hi, lo});
		reading = 0;
		fahr = 0;
		r.computed_crc = frame_crc8(hi, lo);
		if (berr) begin
			r.status = ST_BUS_ERROR;
		end else if (r.computed_crc != chk) begin
			r.status = ST_CRC_MISMATCH;
		end else begin
			r.status = ST_OK;
			if (kind == KIND_TEMP) begin
				reading = longint'((64'd17500 * raw) >> 16) - 4500;
				fahr = longint'((64'd31500 * raw) >> 16) - 4900;
			end else begin
				reading = longint'((64'd10000 * raw) >> 16);
			end
		end
		r.reading_centi = reading[14:0];
		r.fahrenheit_centi = fahr[15:0];
		return r;
	endfunction

	task automatic send_frame(input kind_t kind, input logic [7:0] hi, input logic [7:0] lo,
		input logic [7:0] chk, input logic berr);
		int gap;
		frame_bus.valid      <= 1'b1;
		frame_bus.kind       <= kind;
		frame_bus.data_high  <= hi;
		frame_bus.data_low   <= lo;
		frame_bus.check_byte <= chk;
		frame_bus.bus_error  <= berr;
		do @(posedge clk); while (!frame_bus.ready);
		expected_results.push_back(convert_frame(kind, hi, lo, chk, berr));
		if (tx_bursty) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				frame_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_good(input kind_t kind, input logic [15:0] raw);
		send_frame(kind, raw[15:8], raw[7:0], frame_crc8(raw[15:8], raw[7:0]), 1'b0);
	endtask

	task automatic send_random_frame(input int good_pct);
		kind_t      kind;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] chk;
		int         pick;
		kind = kind_t'($urandom_range(0, 1));
		hi = 8'($urandom_range(0, 255));
		lo = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < good_pct) begin
			send_frame(kind, hi, lo, frame_crc8(hi, lo), 1'b0);
		end else if (pick < good_pct + (100 - good_pct) / 2) begin
			chk = frame_crc8(hi, lo) ^ 8'($urandom_range(1, 255));
			send_frame(kind, hi, lo, chk, 1'b0);
		end else begin
			chk = ($urandom_range(0, 1) == 0) ? frame_crc8(hi, lo) : 8'($urandom_range(0, 255));
			send_frame(kind, hi, lo, chk, 1'b1);
		end
	endtask

	task automatic wait_drained();
		frame_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		tx_bursty = 1'b0;
		rx_stalls = 1'b0;
		send_good(KIND_TEMP, 16'h0000);
		send_good(KIND_TEMP, 16'hFFFF);
		send_good(KIND_HUMID, 16'h0000);
		send_good(KIND_HUMID, 16'hFFFF);
		send_frame(KIND_TEMP, 8'hBE, 8'hEF, 8'h92, 1'b0);
		send_good(KIND_TEMP, 16'h8000);
		send_good(KIND_HUMID, 16'h8000);
		send_good(KIND_TEMP, 16'h6666);
		send_good(KIND_HUMID, 16'h0001);
		send_frame(KIND_TEMP, 8'h12, 8'h34, frame_crc8(8'h12, 8'h34) ^ 8'h01, 1'b0);
		send_frame(KIND_TEMP, 8'hFF, 8'h00, frame_crc8(8'hFF, 8'h00) ^ 8'h80, 1'b0);
		send_frame(KIND_HUMID, 8'h00, 8'hFF, frame_crc8(8'h00, 8'hFF) ^ 8'hFF, 1'b0);
		send_frame(KIND_TEMP, 8'h55, 8'hAA, frame_crc8(8'h55, 8'hAA), 1'b1);
		send_frame(KIND_HUMID, 8'hAA, 8'h55, frame_crc8(8'hAA, 8'h55) ^ 8'h10, 1'b1);
		send_frame(KIND_TEMP, 8'hFF, 8'hFF, 8'h00, 1'b1);
		send_frame(KIND_HUMID, 8'h00, 8'h00, 8'hFF, 1'b0);
		send_frame(KIND_TEMP, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_frame(KIND_HUMID, 8'hFF, 8'hFF, 8'h00, 1'b0);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		tx_bursty = 1'b0;
		rx_stalls = 1'b0;
		repeat (100) send_random_frame(80);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		tx_bursty = 1'b1;
		rx_stalls = 1'b1;
		burst_left = $urandom_range(1, 20);
		repeat (1100) send_random_frame(70);
		wait_drained();
	endtask

	task automatic test_output_hold();
		tx_bursty = 1'b0;
		rx_stalls = 1'b0;
		hold_request = 1'b1;
		repeat (80) send_random_frame(70);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		tx_bursty = 1'b1;
		rx_stalls = 1'b1;
		burst_left = $urandom_range(1, 20);
		repeat (40) send_random_frame(70);
		wait_drained();
		repeat (40) send_random_frame(70);
		wait_drained();
	endtask

	initial begin : result_monitor
		conv_result_t exp;
		int           hold_left;
		int           rx_phase;
		logic [31:0]  rx_pattern;
		hold_left = 0;
		rx_phase = 0;
		rx_pattern = '1;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result transaction: status %0d reading %0d fahr %0d crc %02h",
							result_bus.status, result_bus.reading_centi,
							result_bus.fahrenheit_centi, result_bus.computed_crc);
					end
				end else begin
					exp = expected_results.pop_front();
					if (result_bus.status !== exp.status
						|| result_bus.reading_centi !== exp.reading_centi
						|| result_bus.fahrenheit_centi !== exp.fahrenheit_centi
						|| result_bus.computed_crc !== exp.computed_crc) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp status %0d reading %0d fahr %0d crc %02h",
								exp.status, exp.reading_centi, exp.fahrenheit_centi,
								exp.computed_crc);
							$display("          got status %0d reading %0d fahr %0d crc %02h",
								result_bus.status, result_bus.reading_centi,
								result_bus.fahrenheit_centi, result_bus.computed_crc);
						end
					end
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (!rx_stalls) begin
				result_bus.ready <= 1'b1;
			end else begin
				if (rx_phase == 0) begin
					case ($urandom_range(0, 3))
						0: rx_pattern = '1;
						1: rx_pattern = $urandom & $urandom;
						default: rx_pattern = $urandom | $urandom;
					endcase
				end
				result_bus.ready <= rx_pattern[rx_phase[4:0]];
				rx_phase = (rx_phase + 1) % 32;
			end
		end
	end

	always @(posedge clk) begin
		if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("sensor_frame_crc_convert_core test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		frame_bus.valid      <= 1'b0;
		frame_bus.kind       <= KIND_TEMP;
		frame_bus.data_high  <= 8'h00;
		frame_bus.data_low   <= 8'h00;
		frame_bus.check_byte <= 8'h00;
		frame_bus.bus_error  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_random_traffic();
		test_output_hold();
		test_drain_pause();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("sensor_frame_crc_convert_core test passed");
		end else begin
			$display("sensor_frame_crc_convert_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
